// ===== rtl/scfla_pkg.sv =====
// Shared types and constants for the size class allocator.
package scfla_pkg;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_NO_MEMORY = 2'd2;

    localparam logic [5:0] BATCH_RESET = 6'd20;
    localparam logic [5:0] BATCH_MAX   = 6'd32;

    typedef struct packed {
        logic [15:0] granted_addr;
        logic [1:0]  status;
    } result_t;

endpackage

// ===== rtl/scfla_ram.sv =====
// Generic single-port RAM with registered read data.
module scfla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/size_class_free_list_allocator.sv =====
// Top level of the segregated free list allocator for small blocks.
// An oversize request or a null free goes straight to the result; a free pushes the block onto
// its list; a pop reads the link word and writes it back as the head; a refill carves n blocks
// from the pool and links the rest onto the list. A refill may first grow the pool, push a
// leftover, divide a short pool, or scan larger classes for a block to use as the pool.
// One item is in work at a time; the output register lets the next item start while a result
// waits. Reset is synchronous on aresetn low; all lists start empty, no memory sweep.
module size_class_free_list_allocator #(
    parameter int HEAP_BYTES      = 65536,
    parameter int ALIGN_BYTES     = 8,
    parameter int MAX_SMALL_BYTES = 128,
    parameter int NUM_CLASSES     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // size_bytes, block_addr
    input  logic        s_tuser,   // cmd
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [23:0] m_tdata    // granted_addr, status, zero fill
);

    localparam int AW = $clog2(ALIGN_BYTES);
    localparam int LD = 65536 / ALIGN_BYTES;
    localparam int LW = $clog2(LD);
    localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam logic [16:0] LIMIT = (HEAP_BYTES > 65536) ? 17'd65536 : 17'(HEAP_BYTES);
    localparam logic [16:0] MAXS  = 17'(MAX_SMALL_BYTES);
    localparam logic [16:0] ALN   = 17'(ALIGN_BYTES);

    localparam logic [3:0] S_IDLE = 4'd0, S_POPRD = 4'd1, S_POPWB = 4'd2,
        S_CARVE = 4'd3, S_DIV = 4'd4, S_LEFT = 4'd5, S_GROW = 4'd6,
        S_SCAN = 4'd7, S_SCANWB = 4'd9, S_LINK = 4'd10,
        S_OUT = 4'd11, S_PUSH = 4'd12;

    logic [3:0]  state_reg;
    logic [5:0]  batch_reg;
    logic [15:0] heads_reg [NUM_CLASSES];
    logic [16:0] pb_reg, pe_reg, ho_reg, hn_reg;
    logic [16:0] sz_reg, scan_reg, total_reg, left_reg;
    logic [15:0] addr_reg, chunk_reg;
    logic [CW-1:0] cls_reg;
    logic [5:0]  count_reg, k_reg;
    logic [2:0]  pass_reg;
    logic [16:0] rem_reg, quo_reg;
    logic [4:0]  dbit_reg;
    logic        ovalid_reg;
    scfla_pkg::result_t res_reg;
    scfla_pkg::result_t out_reg;

    logic          we;
    logic [LW-1:0] ra;
    logic [15:0]   wd, rd;

    scfla_ram #(.WIDTH(16), .DEPTH(LD)) u_link (
        .aclk(aclk), .we(we), .addr(ra), .wdata(wd), .rdata(rd));

    function automatic logic [CW-1:0] cls_of(input logic [16:0] b);
        logic [16:0] c;
        c = (b + ALN - 17'd1) >> AW;
        c = (c == 17'd0) ? 17'd0 : c - 17'd1;
        return (c >= 17'(NUM_CLASSES)) ? CW'(NUM_CLASSES - 1) : c[CW-1:0];
    endfunction

    logic [16:0] in_size;
    assign in_size = (s_tdata[15:0] == 16'd0) ? 17'd1 : {1'b0, s_tdata[15:0]};
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = {6'd0, out_reg.status, out_reg.granted_addr};

    logic [16:0] left_c, want_c, here_c, dsub;
    assign left_c = (pe_reg >= pb_reg) ? pe_reg - pb_reg : 17'd0;
    assign want_c = {total_reg[15:0], 1'b0}
                  + (((ho_reg >> 4) + ALN - 17'd1) >> AW << AW);
    assign here_c = {1'b0, chunk_reg} + 17'(k_reg) * sz_reg;
    assign dsub   = {rem_reg[15:0], quo_reg[16]};

    always_comb begin
        we = 1'b0;
        ra = addr_reg[AW +: LW];
        wd = 16'd0;
        case (state_reg)
            S_POPRD:  ra = heads_reg[cls_reg][AW +: LW];
            S_PUSH: begin
                we = 1'b1;
                wd = heads_reg[cls_reg];
            end
            S_LEFT: begin
                we = 1'b1;
                ra = pb_reg[AW +: LW];
                wd = heads_reg[cls_of(left_reg)];
            end
            S_SCAN:   ra = heads_reg[cls_of(scan_reg)][AW +: LW];
            S_LINK: begin
                we = (count_reg > 6'd1);
                ra = here_c[AW +: LW];
                wd = (k_reg + 6'd1 == count_reg) ? 16'd0 : 16'(here_c + sz_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            batch_reg  <= scfla_pkg::BATCH_RESET;
            pb_reg     <= 17'd0;
            pe_reg     <= 17'd0;
            ho_reg     <= 17'd0;
            hn_reg     <= 17'd8;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                heads_reg[i] <= 16'd0;
            end
        end else begin
            if (cfg_valid) begin
                batch_reg <= cfg_data;
            end
            if (state_reg == S_OUT && (!ovalid_reg || m_tready)) begin
                ovalid_reg <= 1'b1;
                out_reg    <= res_reg;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: if (s_tvalid && s_tready) begin
                    addr_reg <= s_tdata[31:16];
                    cls_reg  <= cls_of(in_size);
                    sz_reg   <= (in_size + ALN - 17'd1) >> AW << AW;
                    count_reg <= (batch_reg == 6'd0) ? 6'd1 :
                        (batch_reg > scfla_pkg::BATCH_MAX) ? scfla_pkg::BATCH_MAX : batch_reg;
                    pass_reg <= 3'd0;
                    res_reg  <= '{16'd0, (in_size > MAXS) ? scfla_pkg::ST_TOO_LARGE
                                                          : scfla_pkg::ST_DONE};
                    if (in_size > MAXS) begin
                        state_reg <= S_OUT;
                    end else if (s_tuser == scfla_pkg::CMD_FREE) begin
                        state_reg <= (s_tdata[31:16] != 16'd0) ? S_PUSH : S_OUT;
                    end else if (heads_reg[cls_of(in_size)] != 16'd0) begin
                        state_reg <= S_POPRD;
                    end else begin
                        state_reg <= S_CARVE;
                    end
                end
                S_PUSH: begin
                    heads_reg[cls_reg] <= addr_reg;
                    state_reg <= S_OUT;
                end
                S_POPRD: begin
                    res_reg.granted_addr <= heads_reg[cls_reg];
                    state_reg <= S_POPWB;
                end
                S_POPWB: begin
                    heads_reg[cls_reg] <= rd;
                    state_reg <= S_OUT;
                end
                S_CARVE: begin
                    total_reg <= 17'(sz_reg * 17'(count_reg));
                    left_reg  <= left_c;
                    if (pass_reg == 3'd4) begin
                        res_reg.status <= scfla_pkg::ST_NO_MEMORY;
                        state_reg <= S_OUT;
                    end else if (left_c >= 17'(sz_reg * 17'(count_reg))) begin
                        chunk_reg <= pb_reg[15:0];
                        pb_reg <= pb_reg + 17'(sz_reg * 17'(count_reg));
                        k_reg <= 6'd1;
                        state_reg <= S_LINK;
                    end else if (left_c >= sz_reg) begin
                        rem_reg <= 17'd0;
                        quo_reg <= left_c;
                        dbit_reg <= 5'd0;
                        state_reg <= S_DIV;
                    end else if (left_c != 17'd0) begin
                        state_reg <= S_LEFT;
                    end else begin
                        state_reg <= S_GROW;
                    end
                end
                S_DIV: begin
                    if (dsub >= sz_reg) begin
                        rem_reg <= dsub - sz_reg;
                        quo_reg <= {quo_reg[15:0], 1'b1};
                    end else begin
                        rem_reg <= dsub;
                        quo_reg <= {quo_reg[15:0], 1'b0};
                    end
                    dbit_reg <= dbit_reg + 5'd1;
                    if (dbit_reg == 5'd16) begin
                        count_reg <= (dsub >= sz_reg) ? {quo_reg[4:0], 1'b1}
                                                      : {quo_reg[4:0], 1'b0};
                        total_reg <= left_reg;
                        state_reg <= S_CARVE;
                    end
                end
                S_LEFT: begin
                    heads_reg[cls_of(left_reg)] <= pb_reg[15:0];
                    state_reg <= S_GROW;
                end
                S_GROW: begin
                    pass_reg <= pass_reg + 3'd1;
                    if (hn_reg <= LIMIT && want_c <= LIMIT - hn_reg) begin
                        pb_reg <= hn_reg;
                        pe_reg <= hn_reg + want_c;
                        hn_reg <= hn_reg + want_c;
                        ho_reg <= ho_reg + want_c;
                        state_reg <= S_CARVE;
                    end else begin
                        pb_reg <= 17'd0;
                        pe_reg <= 17'd0;
                        scan_reg <= sz_reg;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_reg > MAXS) begin
                        res_reg.status <= scfla_pkg::ST_NO_MEMORY;
                        state_reg <= S_OUT;
                    end else if (heads_reg[cls_of(scan_reg)] != 16'd0) begin
                        state_reg <= S_SCANWB;
                    end else begin
                        scan_reg <= scan_reg + ALN;
                    end
                end
                S_SCANWB: begin
                    pb_reg <= {1'b0, heads_reg[cls_of(scan_reg)]};
                    pe_reg <= {1'b0, heads_reg[cls_of(scan_reg)]} + scan_reg;
                    heads_reg[cls_of(scan_reg)] <= rd;
                    state_reg <= S_CARVE;
                end
                S_LINK: begin
                    res_reg.granted_addr <= chunk_reg;
                    if (count_reg <= 6'd1) begin
                        state_reg <= S_OUT;
                    end else begin
                        heads_reg[cls_reg] <= 16'(chunk_reg + sz_reg);
                        k_reg <= k_reg + 6'd1;
                        if (k_reg + 6'd1 == count_reg) begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!ovalid_reg || m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed while held");
    a_null: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17:16] != scfla_pkg::ST_DONE |-> m_tdata[15:0] == 16'd0)
        else $error("address granted on failure");
`endif

endmodule

// ===== dv/tb_size_class_free_list_allocator.sv =====
// Self-checking testbench for the size class free list allocator.
`timescale 1ns / 100ps

module tb_size_class_free_list_allocator;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tready = 1'b0;
    logic        m_tvalid;
    logic [23:0] m_tdata;

    size_class_free_list_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata)
    );

    localparam int HEAP_TOP   = 65536;
    localparam int GRAIN      = 8;
    localparam int SMALL_MAX  = 128;
    localparam int CLASSES    = 16;
    localparam int LINK_WORDS = 65536 / GRAIN;
    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        logic        cmd;
        logic [15:0] size;
        logic [15:0] addr;
        bit          typed;
        logic [15:0] granted;
        logic [1:0]  status;
    } stim_row_t;

    // Allocator shadow state.
    logic [15:0] link_mem [LINK_WORDS];
    int unsigned list_head [CLASSES];
    int unsigned pool_lo, pool_hi, heap_got, heap_top;
    int unsigned batch_reg;

    scfla_pkg::result_t pending_results [$];
    logic [15:0] live_addr [$];
    logic [15:0] live_size [$];

    int errors, beats_in, beats_out, n_grant, n_free, n_oom, n_big;
    int idle_cycles = 0;
    bit stim_done;

    function automatic int unsigned size_class(int unsigned b);
        int unsigned c;
        c = (b + GRAIN - 1) / GRAIN;
        c = (c == 0) ? 0 : c - 1;
        return (c >= CLASSES) ? CLASSES - 1 : c;
    endfunction

    function automatic int unsigned link_slot(int unsigned a);
        return ((a & 16'hFFFF) / GRAIN) % LINK_WORDS;
    endfunction

    function automatic int unsigned align_up(int unsigned b);
        return ((b + GRAIN - 1) / GRAIN) * GRAIN;
    endfunction

    task automatic push_free(int unsigned c, int unsigned a);
        link_mem[link_slot(a)] = list_head[c][15:0];
        list_head[c] = a & 16'hFFFF;
    endtask

    task automatic carve_pool(input int unsigned sz, inout int unsigned count,
                              output int unsigned chunk, output bit ok);
        int unsigned total, left, want, i, c, p;
        ok = 0;
        chunk = 0;
        for (int pass = 0; pass < 4; pass++) begin
            total = sz * count;
            left  = (pool_hi >= pool_lo) ? pool_hi - pool_lo : 0;
            if (left >= total) begin
                chunk = pool_lo;
                pool_lo += total;
                ok = 1;
                return;
            end
            if (left >= sz) begin
                count = left / sz;
                chunk = pool_lo;
                pool_lo += sz * count;
                ok = 1;
                return;
            end
            want = 2 * total + align_up(heap_got >> 4);
            if (left > 0)
                push_free(size_class(left), pool_lo);
            pool_lo = 0;
            pool_hi = 0;
            if (heap_top <= HEAP_TOP && want <= HEAP_TOP - heap_top) begin
                pool_lo = heap_top;
                pool_hi = heap_top + want;
                heap_top += want;
                heap_got += want;
                continue;
            end
            for (i = sz; i <= SMALL_MAX; i += GRAIN) begin
                c = size_class(i);
                p = list_head[c];
                if (p != 0) begin
                    list_head[c] = 32'(link_mem[link_slot(p)]);
                    pool_lo = p;
                    pool_hi = p + i;
                    break;
                end
            end
            if (i > SMALL_MAX)
                return;
        end
    endtask

    task automatic predict_allocator(input logic cmd, input logic [15:0] size_in,
                                     input logic [15:0] addr, output scfla_pkg::result_t r);
        int unsigned size, c, sz, count, chunk, here;
        bit ok;
        size = (size_in == 16'd0) ? 1 : 32'(size_in);
        r.granted_addr = '0;
        r.status = scfla_pkg::ST_DONE;
        if (size > SMALL_MAX) begin
            r.status = scfla_pkg::ST_TOO_LARGE;
        end else if (cmd == scfla_pkg::CMD_FREE) begin
            if (addr != 16'd0)
                push_free(size_class(size), 32'(addr));
        end else begin
            c = size_class(size);
            if (list_head[c] != 0) begin
                r.granted_addr = list_head[c][15:0];
                list_head[c] = 32'(link_mem[link_slot(list_head[c])]);
            end else begin
                sz = align_up(size);
                count = batch_reg;
                if (count == 0)
                    count = 1;
                if (count > 32'(scfla_pkg::BATCH_MAX))
                    count = 32'(scfla_pkg::BATCH_MAX);
                carve_pool(sz, count, chunk, ok);
                if (!ok) begin
                    r.status = scfla_pkg::ST_NO_MEMORY;
                end else begin
                    r.granted_addr = chunk[15:0];
                    if (count > 1) begin
                        list_head[c] = (chunk + sz) & 16'hFFFF;
                        for (int unsigned k = 1; k < count; k++) begin
                            here = chunk + k * sz;
                            link_mem[link_slot(here)] =
                                (k + 1 == count) ? 16'h0 : 16'((here + sz) & 16'hFFFF);
                        end
                    end
                end
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        $display("MISMATCH beat %0d %s: got 0x%0h, expected 0x%0h", beats_out, what, got, want);
    endtask

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: checks result beats and switches between random stall patterns.
    int unsigned stall_mode = 0;
    int unsigned stall_ctr = 0;
    always @(posedge aclk) begin
        scfla_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("MISMATCH result beat %0d with nothing pending", beats_out);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.granted_addr)
                    report_mismatch("granted_addr", m_tdata[15:0], want.granted_addr);
                if (m_tdata[17:16] !== want.status)
                    report_mismatch("status", 16'(m_tdata[17:16]), 16'(want.status));
            end
        end
        if (stall_ctr == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_ctr  <= 64;
        end else begin
            stall_ctr <= stall_ctr - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 0);
            2: m_tready <= ($urandom_range(0, 9) != 0);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("tb_size_class_free_list_allocator: done, errors");
            $finish;
        end
    end

    int unsigned burst_left;

    task automatic send_request(logic cmd, logic [15:0] size, logic [15:0] addr,
                                bit typed, scfla_pkg::result_t typed_res);
        scfla_pkg::result_t r;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0 && s_tvalid) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {addr, size};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        beats_in++;
        predict_allocator(cmd, size, addr, r);
        pending_results.push_back(typed ? typed_res : r);
        if (size != 16'd0 && size <= SMALL_MAX) begin
            if (cmd == scfla_pkg::CMD_FREE) n_free++;
            else if (r.status == scfla_pkg::ST_NO_MEMORY) n_oom++;
            else begin
                n_grant++;
                live_addr.push_back(r.granted_addr);
                live_size.push_back(size);
            end
        end else if (size > SMALL_MAX) begin
            n_big++;
        end
    endtask

    task automatic write_batch(logic [5:0] v);
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        batch_reg = 32'(v);
        cfg_valid <= 1'b0;
        burst_left = 0;
    endtask

    stim_row_t directed [24] = '{
        '{scfla_pkg::CMD_ALLOC, 16'd8,     16'h0000, 1, 16'd8, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_ALLOC, 16'd0,     16'h0000, 0, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_ALLOC, 16'd128,   16'h0000, 0, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_ALLOC, 16'd129,   16'h0000, 1, 16'd0, scfla_pkg::ST_TOO_LARGE},
        '{scfla_pkg::CMD_ALLOC, 16'd65535, 16'hFFFF, 1, 16'd0, scfla_pkg::ST_TOO_LARGE},
        '{scfla_pkg::CMD_FREE,  16'd8,     16'h0000, 1, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_FREE,  16'd300,   16'h0008, 1, 16'd0, scfla_pkg::ST_TOO_LARGE},
        '{scfla_pkg::CMD_FREE,  16'd65535, 16'hFFFF, 1, 16'd0, scfla_pkg::ST_TOO_LARGE},
        '{scfla_pkg::CMD_FREE,  16'd1,     16'hFFFF, 1, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_ALLOC, 16'd1,     16'h0000, 0, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_FREE,  16'd5,     16'h0008, 1, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_ALLOC, 16'd7,     16'h0000, 0, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_ALLOC, 16'd9,     16'h0000, 0, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_ALLOC, 16'd16,    16'h0000, 0, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_ALLOC, 16'd17,    16'h0000, 0, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_ALLOC, 16'd64,    16'h0000, 0, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_ALLOC, 16'd100,   16'h0000, 0, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_ALLOC, 16'd127,   16'h0000, 0, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_FREE,  16'd120,   16'h0010, 1, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_ALLOC, 16'd120,   16'h0000, 0, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_FREE,  16'd64,    16'hAAAA, 1, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_FREE,  16'd16,    16'h5555, 1, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_ALLOC, 16'd64,    16'h0000, 0, 16'd0, scfla_pkg::ST_DONE},
        '{scfla_pkg::CMD_ALLOC, 16'd16,    16'h0000, 0, 16'd0, scfla_pkg::ST_DONE}
    };

    logic [5:0] phase_batch [6] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd7, 6'd20};

    initial begin
        scfla_pkg::result_t tr;
        int unsigned pick, roll;
        logic [15:0] sz, ad;
        aresetn = 0;
        cfg_valid = 0;
        cfg_data = '0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 1'b0;
        errors = 0; beats_in = 0; beats_out = 0;
        n_grant = 0; n_free = 0; n_oom = 0; n_big = 0;
        stim_done = 0; burst_left = 0;
        batch_reg = 32'(scfla_pkg::BATCH_RESET);
        foreach (list_head[i]) list_head[i] = 0;
        pool_lo = 0; pool_hi = 0; heap_got = 0; heap_top = 8;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            tr.granted_addr = directed[i].granted;
            tr.status = directed[i].status;
            send_request(directed[i].cmd, directed[i].size, directed[i].addr,
                         directed[i].typed, tr);
        end

        foreach (phase_batch[ph]) begin
            write_batch(ph == 5 ? 6'($urandom_range(0, 63)) : phase_batch[ph]);
            repeat (265) begin
                roll = $urandom_range(0, 99);
                if (roll < 40 && live_addr.size() != 0) begin
                    pick = $urandom_range(0, live_addr.size() - 1);
                    ad = live_addr[pick];
                    sz = live_size[pick];
                    live_addr.delete(pick);
                    live_size.delete(pick);
                    send_request(scfla_pkg::CMD_FREE, sz, ad, 0, tr);
                end else if (roll < 88) begin
                    sz = (ph == 1) ? 16'($urandom_range(96, 128))
                                   : 16'($urandom_range(1, 128));
                    send_request(scfla_pkg::CMD_ALLOC, sz, 16'($urandom), 0, tr);
                end else if (roll < 93) begin
                    send_request(scfla_pkg::CMD_FREE, 16'($urandom_range(0, 128)),
                                 16'($urandom), 0, tr);
                end else if (roll < 97) begin
                    send_request(1'($urandom), 16'($urandom), 16'($urandom), 0, tr);
                end else begin
                    send_request(scfla_pkg::CMD_ALLOC, 16'd0, 16'($urandom), 0, tr);
                end
            end
        end

        s_tvalid <= 1'b0;
        stim_done = 1;
        for (int w = 0; w < 200000 && pending_results.size() != 0; w++)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Ran %0d request beats and checked %0d result beats over six batch settings.",
                 beats_in, beats_out);
        $display("Grants %0d, frees %0d, out of memory %0d, oversize %0d.",
                 n_grant, n_free, n_oom, n_big);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb_size_class_free_list_allocator: done, clean");
        end else begin
            $display("tb_size_class_free_list_allocator: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/scfla_pkg.sv
rtl/scfla_ram.sv
rtl/size_class_free_list_allocator.sv
dv/tb_size_class_free_list_allocator.sv
